// File: sv/cs_pkg.sv
// ---------------------------------------------------------------------------
// cs_pkg
// Types and constants shared by the cosine similarity stream core.
// ---------------------------------------------------------------------------
`default_nettype none

package cs_pkg;

  localparam int ELEM_FIELD_W = 16;
  localparam int SIM_W        = 16;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic signed [ELEM_FIELD_W-1:0] element_a;
    logic signed [ELEM_FIELD_W-1:0] element_b;
    logic                           last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    undefined;
    logic                    length_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TRIAL_A,
    ST_TRIAL_B,
    ST_FIN
  } back_state_t;

endpackage

`default_nettype wire

// File: sv/cs_front.sv
// ---------------------------------------------------------------------------
// cs_front
// Accepts element pairs, forms products and accumulates dot product and
// squared norms; on the last pair pushes the totals to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module cs_front #(
  parameter int ELEMENT_BITS,
  parameter int MAX_DIMENSION,
  localparam int MAG_W = 2 * ELEMENT_BITS - 1 + $clog2(MAX_DIMENSION),
  localparam int DOT_W = MAG_W + 1,
  localparam int REC_W = DOT_W + 2 * MAG_W + 1,
  localparam int QC_W  = $clog2(cs_pkg::QUEUE_DEPTH + 1)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  cs_pkg::in_item_t in_item,
  input  wire [QC_W-1:0]   q_count,
  output logic             push,
  output logic [REC_W-1:0] push_data
);

  localparam int PW    = 2 * ELEMENT_BITS;
  localparam int CNT_W = $clog2(MAX_DIMENSION + 1);
  localparam int RW    = (ELEMENT_BITS > cs_pkg::ELEM_FIELD_W) ? ELEMENT_BITS
                                                               : cs_pkg::ELEM_FIELD_W;

  logic [RW-1:0] raw_a, raw_b;
  logic signed [ELEMENT_BITS-1:0] elem_a, elem_b;
  logic accept, keep;

  logic             s1_valid_r, s1_keep_r, s1_last_r;
  logic signed [PW-1:0] pab_r, paa_r, pbb_r;
  logic [CNT_W-1:0] cnt_r;

  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [MAG_W-1:0] na_r, na_nxt, nb_r, nb_nxt;
  logic ovf_r, ovf_nxt;

  // fields narrower than the element are zero padded, then sign taken from the top element bit
  assign raw_a  = RW'($unsigned(in_item.element_a));
  assign raw_b  = RW'($unsigned(in_item.element_b));
  assign elem_a = $signed(raw_a[ELEMENT_BITS-1:0]);
  assign elem_b = $signed(raw_b[ELEMENT_BITS-1:0]);

  // one slot reserved for a last pair still in the product stage
  assign in_stall = ({1'b0, q_count} + (QC_W+1)'(s1_valid_r && s1_last_r))
                    >= (QC_W+1)'(cs_pkg::QUEUE_DEPTH);
  assign accept = in_valid && !in_stall;
  assign keep   = cnt_r < CNT_W'(MAX_DIMENSION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        if (in_item.last_element) begin
          cnt_r <= '0;
        end else if (keep) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_keep_r <= keep;
      s1_last_r <= in_item.last_element;
      pab_r     <= elem_a * elem_b;
      paa_r     <= elem_a * elem_a;
      pbb_r     <= elem_b * elem_b;
    end
  end

  always_comb begin
    dot_nxt = dot_r;
    na_nxt  = na_r;
    nb_nxt  = nb_r;
    ovf_nxt = ovf_r;
    if (s1_keep_r) begin
      dot_nxt = dot_r + DOT_W'(pab_r);
      na_nxt  = na_r + MAG_W'($unsigned(paa_r));
      nb_nxt  = nb_r + MAG_W'($unsigned(pbb_r));
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign push      = s1_valid_r && s1_last_r;
  assign push_data = {ovf_nxt, nb_nxt, na_nxt, dot_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      ovf_r <= 1'b0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        dot_r <= '0;
        na_r  <= '0;
        nb_r  <= '0;
        ovf_r <= 1'b0;
      end else begin
        dot_r <= dot_nxt;
        na_r  <= na_nxt;
        nb_r  <= nb_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/cs_queue.sv
// ---------------------------------------------------------------------------
// cs_queue
// Small FIFO of finished accumulator sets between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module cs_queue #(
  parameter int DW,
  localparam int DEPTH = cs_pkg::QUEUE_DEPTH,
  localparam int AW    = $clog2(DEPTH),
  localparam int QC_W  = $clog2(DEPTH + 1)
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  wire  [DW-1:0]   push_data,
  input  wire             pop,
  output logic            head_valid,
  output logic [DW-1:0]   head_data,
  output logic [QC_W-1:0] count
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [QC_W-1:0] count_r;
  logic do_pop;

  assign head_valid = count_r != '0;
  assign head_data  = mem_r[rp_r];
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + AW'(1);
      end
      count_r <= count_r + QC_W'(push) - QC_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: sv/cs_back.sv
// ---------------------------------------------------------------------------
// cs_back
// Exact fixed point quotient dot / sqrt(na * nb): shift-add products, then
// one quotient bit per ST_TRIAL_A/ST_TRIAL_B pass by incremental squaring.
// ---------------------------------------------------------------------------
`default_nettype none

module cs_back #(
  parameter int MAG_W,
  parameter int RESULT_FRACTION_BITS,
  localparam int DOT_W = MAG_W + 1,
  localparam int REC_W = DOT_W + 2 * MAG_W + 1
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               head_valid,
  input  wire  [REC_W-1:0]  head_data,
  output logic              pop,
  output logic              out_valid,
  input  wire               out_stall,
  output cs_pkg::out_item_t out_item
);

  localparam int F    = RESULT_FRACTION_BITS;
  localparam int W    = 2 * MAG_W + 2 * F + 2;
  localparam int MC_W = $clog2(MAG_W + 1);
  localparam int K_W  = $clog2(F + 1);
  localparam int QW   = F + 1;
  localparam int SW   = F + 18;

  cs_pkg::back_state_t state_r, state_nxt;

  logic signed [DOT_W-1:0] h_dot;
  logic [MAG_W-1:0] h_na, h_nb;
  logic h_ovf, h_zero;

  logic [W-1:0] p_r, l_r, cand_p_r, cand_l_r;
  logic [MAG_W-1:0] mul_p_r, mul_l_r;
  logic [MC_W-1:0] mc_r;
  logic [W-1:0] y_r, qps_r, ps_r, tmp_r, trial;
  logic [K_W-1:0] k_r;
  logic [QW-1:0] q_r;
  logic neg_r, ovf_r, undef_r;
  logic fits;
  logic out_valid_r;
  cs_pkg::out_item_t out_r;
  logic signed [SW-1:0] sq, sat;

  assign {h_ovf, h_nb, h_na, h_dot} = head_data;
  assign h_zero = (h_na == '0) || (h_nb == '0);

  assign trial = y_r + tmp_r;
  assign fits  = trial <= (l_r << (2 * F));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cs_pkg::ST_IDLE: begin
        if (head_valid) begin
          state_nxt = h_zero ? cs_pkg::ST_FIN : cs_pkg::ST_MUL;
        end
      end
      cs_pkg::ST_MUL: begin
        if (mc_r == MC_W'(MAG_W - 1)) begin
          state_nxt = cs_pkg::ST_TRIAL_A;
        end
      end
      cs_pkg::ST_TRIAL_A: state_nxt = cs_pkg::ST_TRIAL_B;
      cs_pkg::ST_TRIAL_B: begin
        state_nxt = (k_r == '0) ? cs_pkg::ST_FIN : cs_pkg::ST_TRIAL_A;
      end
      cs_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = cs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state_r)
      cs_pkg::ST_IDLE: pop = head_valid;
      default:         pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // signed quotient, saturated to the result field
  always_comb begin
    sq = neg_r ? -SW'(q_r) : SW'(q_r);
    if (undef_r) begin
      sat = '0;
    end else if (sq > SW'(32767)) begin
      sat = SW'(32767);
    end else if (sq < -SW'(32768)) begin
      sat = -SW'(32768);
    end else begin
      sat = sq;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cs_pkg::ST_IDLE: begin
        if (head_valid) begin
          ovf_r    <= h_ovf;
          undef_r  <= h_zero;
          neg_r    <= h_dot[DOT_W-1];
          cand_p_r <= W'(h_na);
          mul_p_r  <= h_nb;
          // magnitude may use the top bit, so widen it without sign
          cand_l_r <= h_dot[DOT_W-1] ? W'($unsigned(MAG_W'(-h_dot)))
                                     : W'($unsigned(MAG_W'(h_dot)));
          mul_l_r  <= h_dot[DOT_W-1] ? MAG_W'(-h_dot) : MAG_W'(h_dot);
          p_r      <= '0;
          l_r      <= '0;
          mc_r     <= '0;
          q_r      <= '0;
        end
      end
      cs_pkg::ST_MUL: begin
        if (mul_p_r[0]) p_r <= p_r + cand_p_r;
        if (mul_l_r[0]) l_r <= l_r + cand_l_r;
        cand_p_r <= cand_p_r << 1;
        cand_l_r <= cand_l_r << 1;
        mul_p_r  <= mul_p_r >> 1;
        mul_l_r  <= mul_l_r >> 1;
        mc_r     <= mc_r + MC_W'(1);
        if (mc_r == MC_W'(MAG_W - 1)) begin
          ps_r  <= (mul_p_r[0] ? p_r + cand_p_r : p_r) << (2 * F);
          qps_r <= '0;
          y_r   <= '0;
          k_r   <= K_W'(F);
        end
      end
      cs_pkg::ST_TRIAL_A: begin
        tmp_r <= qps_r + ps_r;
      end
      cs_pkg::ST_TRIAL_B: begin
        q_r  <= {q_r[QW-2:0], fits};
        if (fits) begin
          y_r   <= trial;
          qps_r <= (qps_r >> 1) + ps_r;
        end else begin
          qps_r <= qps_r >> 1;
        end
        ps_r <= ps_r >> 2;
        k_r  <= k_r - K_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == cs_pkg::ST_FIN && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cs_pkg::ST_FIN && (!out_valid_r || !out_stall)) begin
      out_r.similarity      <= sat[cs_pkg::SIM_W-1:0];
      out_r.undefined       <= undef_r;
      out_r.length_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// File: sv/cosine_similarity_stream_core.sv
// Result path: a last pair passes the product stage and the queue, then the back
// end's shift-add product, quotient trials and output register (norm accumulators
// are 2*ELEMENT_BITS-1+log2(MAX_DIMENSION) bits). Throughput: one pair per cycle
// while in_stall is low; the back end works on one vector at a time, so the vector
// result rate is set by its serial product and quotient unit, with a 4 entry queue ahead.
// Reset: synchronous active low rst_n clears accumulators, counters and queue.
// ---------------------------------------------------------------------------
// cosine_similarity_stream_core
// Streaming cosine similarity of two integer vectors in Q1.F fixed point.
// ---------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_stream_core #(
  parameter int ELEMENT_BITS         = 16,
  parameter int MAX_DIMENSION        = 1024,
  parameter int RESULT_FRACTION_BITS = 14
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  cs_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  wire               out_stall,
  output cs_pkg::out_item_t out_item
);

  localparam int MAG_W = 2 * ELEMENT_BITS - 1 + $clog2(MAX_DIMENSION);
  localparam int DOT_W = MAG_W + 1;
  localparam int REC_W = DOT_W + 2 * MAG_W + 1;
  localparam int QC_W  = $clog2(cs_pkg::QUEUE_DEPTH + 1);

  logic             push, pop, head_valid;
  logic [REC_W-1:0] push_data, head_data;
  logic [QC_W-1:0]  q_count;

  cs_front #(
    .ELEMENT_BITS (ELEMENT_BITS),
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_count  (q_count),
    .push     (push),
    .push_data(push_data)
  );

  cs_queue #(
    .DW(REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head_data),
    .count     (q_count)
  );

  cs_back #(
    .MAG_W               (MAG_W),
    .RESULT_FRACTION_BITS(RESULT_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cosine similarity stream core: streams element
// pairs through valid/stall handshakes, predicts each vector's Q1.14 result
// exactly and compares every result transfer field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int FRAC_BITS   = 14;
  localparam int MAX_DIM     = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  cs_pkg::in_item_t  in_item;
  logic              out_valid;
  logic              out_stall;
  cs_pkg::out_item_t out_item;

  cosine_similarity_stream_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  cs_pkg::in_item_t  pair_q[$];
  cs_pkg::out_item_t sim_expect_q[$];

  // predictor state
  longint dot_sum, norm_a_sum, norm_b_sum;
  int     pair_cnt;
  bit     dropped_seen;

  int pairs_planned, pairs_sent, vectors_done, undef_seen, ovf_seen;
  int mismatches, cycles, hold_left;
  bit hold_done;
  int tx_idle, rx_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // exact Q1.F quotient: largest q with q*sqrt(na*nb) <= |dot|*2^F
  task automatic predict_pair(input cs_pkg::in_item_t it);
    longint    a, b;
    cs_pkg::out_item_t r;
    logic [127:0] lhs, rhs, mag;
    longint lo, hi, mid;
    a = it.element_a;
    b = it.element_b;
    if (pair_cnt < MAX_DIM) begin
      dot_sum    += a * b;
      norm_a_sum += a * a;
      norm_b_sum += b * b;
      pair_cnt++;
    end else dropped_seen = 1;
    if (!it.last_element) return;
    r.length_overflow = dropped_seen;
    if (norm_a_sum == 0 || norm_b_sum == 0) begin
      r.similarity = '0;
      r.undefined  = 1;
    end else begin
      mag = (dot_sum < 0) ? 128'(-dot_sum) : 128'(dot_sum);
      lhs = (mag * mag) << (2 * FRAC_BITS);
      lo = 0;
      hi = 1 << FRAC_BITS;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        rhs = 128'(mid) * 128'(mid) * 128'(norm_a_sum) * 128'(norm_b_sum);
        if (rhs <= lhs) lo = mid;
        else hi = mid - 1;
      end
      if (dot_sum < 0) lo = -lo;
      if (lo > 32767) lo = 32767;
      if (lo < -32768) lo = -32768;
      r.similarity = lo[15:0];
      r.undefined  = 0;
    end
    sim_expect_q.push_back(r);
    dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; pair_cnt = 0; dropped_seen = 0;
  endtask

  task automatic add_pair(input int a, input int b, input bit last);
    cs_pkg::in_item_t it;
    it.element_a    = a[15:0];
    it.element_b    = b[15:0];
    it.last_element = last;
    pair_q.push_back(it);
  endtask

  task automatic add_random_vector(input int len);
    int kind, a, b, k;
    kind = $urandom_range(9);
    k = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      a = $urandom_range(65535) - 32768;
      case (kind)
        0: b = a;                                   // parallel
        1: b = -a;                                  // antiparallel
        2: begin a = 0; b = $urandom_range(65535) - 32768; end
        3: begin a = $urandom_range(15) - 8; b = $urandom_range(15) - 8; end
        4: b = (a * k) / 4;
        default: b = $urandom_range(65535) - 32768;
      endcase
      add_pair(a, b, i == len - 1);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_item  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pair_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_item  <= pair_q.pop_front();
        in_valid <= 1;
      end else in_valid <= 0;
    end
  end

  // receiver, with one long hold-off to fill the core
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && pairs_sent > pairs_planned / 2) begin
      hold_done <= 1;
      hold_left <= 1500;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < rx_idle);
  end

  // idle mix by phase of the run
  always_comb begin
    if (pairs_sent < pairs_planned / 3) begin
      tx_idle = 24; rx_idle = 49;
    end else if (pairs_sent < 2 * pairs_planned / 3) begin
      tx_idle = 49; rx_idle = 24;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cs_pkg::out_item_t want;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (in_valid && !in_stall) begin
        predict_pair(in_item);
        pairs_sent <= pairs_sent + 1;
      end
      if (out_valid && !out_stall) begin
        vectors_done <= vectors_done + 1;
        if (out_item.undefined) undef_seen <= undef_seen + 1;
        if (out_item.length_overflow) ovf_seen <= ovf_seen + 1;
        if (sim_expect_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer: %p", out_item);
        end else begin
          want = sim_expect_q.pop_front();
          if (want !== out_item) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display({"result %0d mismatch: expected sim=%0d undef=%b ovf=%b, ",
                        "got sim=%0d undef=%b ovf=%b"},
                vectors_done, want.similarity, want.undefined, want.length_overflow,
                out_item.similarity, out_item.undefined, out_item.length_overflow);
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int len;
    dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; pair_cnt = 0; dropped_seen = 0;
    pairs_sent = 0; vectors_done = 0; undef_seen = 0; ovf_seen = 0;
    mismatches = 0; cycles = 0;
    rst_n = 0;
    // directed: extremes, zero norms, sign cases
    add_pair(-32768, -32768, 1);
    add_pair(-32768, 32767, 1);
    add_pair(32767, 32767, 1);
    add_pair(0, 5, 1);
    add_pair(7, 0, 1);
    add_pair(0, 0, 1);
    add_pair(1, -1, 0); add_pair(-32768, 32767, 0); add_pair(32767, -32768, 1);
    add_pair(3, 4, 0); add_pair(4, -3, 1);
    add_pair(21845, -21846, 0); add_pair(-1, 1, 0); add_pair(100, 99, 1);
    // full length of extreme pairs (largest dot product), then past the bound
    // with the last mark on a dropped pair
    for (int i = 0; i < MAX_DIM + 3; i++)
      add_pair(-32768, (i < MAX_DIM) ? -32768 : 1000 - i, i == MAX_DIM + 2);
    while (pair_q.size() < 1400) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      add_random_vector(len);
    end
    pairs_planned = pair_q.size();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    while (pair_q.size() != 0 || in_valid) @(posedge clk);
    while (sim_expect_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("streamed %0d pairs in %0d vectors (%0d undefined, %0d length overflow)",
      pairs_sent, vectors_done, undef_seen, ovf_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && sim_expect_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/cs_pkg.sv
sv/cs_front.sv
sv/cs_queue.sv
sv/cs_back.sv
sv/cosine_similarity_stream_core.sv
tb/sv/tb_top.sv
